/* sv/spta_pkg.sv */
// ---------------------------------------------------------------------------
// spta_pkg: shared definitions for the sparse polynomial term accumulator
// Command and status codes, coefficient type and parameter defaults.
// ---------------------------------------------------------------------------
package spta_pkg;

  localparam int COEFF_W  = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Parameter defaults for the top level
  localparam int MAX_TERMS_DEF   = 16;
  localparam int DEGREE_BITS_DEF = 8;

  typedef logic signed [COEFF_W-1:0] coeff_t;

  // Commands
  localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // Result status
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_IDX = 2'd3;

  // Control of the shared saturating adder
  typedef struct packed {
    logic   sub;      // subtract the operand instead of adding it
    coeff_t acc;      // stored coefficient, zero for an insertion
    coeff_t operand;  // incoming coefficient
  } alu_ctrl_t;

  // Result of the shared saturating adder
  typedef struct packed {
    coeff_t res;
    logic   sat;
  } alu_res_t;

endpackage

/* sv/spta_term_ram.sv */
// ---------------------------------------------------------------------------
// spta_term_ram: term table storage
// One write port and one read port, read data registered. Contents are
// undefined until written.
// ---------------------------------------------------------------------------
module spta_term_ram #(
  parameter int DEPTH = spta_pkg::MAX_TERMS_DEF,
  parameter int DW    = spta_pkg::DEGREE_BITS_DEF + spta_pkg::COEFF_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/spta_sat_alu.sv */
// ---------------------------------------------------------------------------
// spta_sat_alu: shared saturating Q16.16 adder
// Adds or subtracts two coefficients exactly and clamps to the 32-bit range.
// ---------------------------------------------------------------------------
module spta_sat_alu (
  input  spta_pkg::alu_ctrl_t ctrl,
  output spta_pkg::alu_res_t  result
);

  logic [spta_pkg::COEFF_W:0] sum;

  // Form the sum one bit wider than the operands
  always_comb begin
    if (ctrl.sub) begin
      sum = {ctrl.acc[spta_pkg::COEFF_W-1], ctrl.acc}
          - {ctrl.operand[spta_pkg::COEFF_W-1], ctrl.operand};
    end else begin
      sum = {ctrl.acc[spta_pkg::COEFF_W-1], ctrl.acc}
          + {ctrl.operand[spta_pkg::COEFF_W-1], ctrl.operand};
    end
  end

  // Clamp on overflow: the two top bits disagree
  always_comb begin
    result.sat = sum[spta_pkg::COEFF_W] ^ sum[spta_pkg::COEFF_W-1];
    if (!result.sat) begin
      result.res = sum[spta_pkg::COEFF_W-1:0];
    end else if (sum[spta_pkg::COEFF_W]) begin
      result.res = {1'b1, {(spta_pkg::COEFF_W-1){1'b0}}};
    end else begin
      result.res = {1'b0, {(spta_pkg::COEFF_W-1){1'b1}}};
    end
  end

endmodule

/* sv/sparse_poly_term_accumulator.sv */
// ---------------------------------------------------------------------------
// sparse_poly_term_accumulator: sorted sparse polynomial term table
// Holds (degree, coefficient) terms by descending degree; adds, subtracts,
// replaces or reads one term per transaction with a shared saturating adder.
// ---------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_ready   | command, term_degree, term_coeff, read_index
//  out_    | output    | out_valid / out_ready | term_count, degree, coeff, status
//
// Sequence: replace and a read of an unused index go straight to the result; a
// read issues the table read and then takes the registered data; add or subtract
// reads and then checks each entry scanned, and reads and then writes each entry shifted down.
// The table memory's single read port with registered data sets this order of steps.
// Reset empties the table at once; no clearing pass is needed.
// A new transaction is taken as soon as the sequencer is idle, while the
// previous result may still wait in the output register.
// ---------------------------------------------------------------------------
module sparse_poly_term_accumulator #(
  parameter int MAX_TERMS   = spta_pkg::MAX_TERMS_DEF,
  parameter int DEGREE_BITS = spta_pkg::DEGREE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spta_pkg::CMD_W-1:0]           in_command,
  input  logic [DEGREE_BITS-1:0]               in_term_degree,
  input  spta_pkg::coeff_t                     in_term_coeff,
  input  logic [$clog2(MAX_TERMS)-1:0]         in_read_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [$clog2(MAX_TERMS+1)-1:0]       out_term_count,
  output logic [DEGREE_BITS-1:0]               out_degree,
  output spta_pkg::coeff_t                     out_coeff,
  output logic [spta_pkg::STATUS_W-1:0]        out_status
);

  localparam int IDX_W = $clog2(MAX_TERMS);
  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int ENT_W = DEGREE_BITS + spta_pkg::COEFF_W;

  // Sequencer states
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN_RD   = 4'd1;
  localparam logic [3:0] S_SCAN_CHK  = 4'd2;
  localparam logic [3:0] S_INSERT    = 4'd3;
  localparam logic [3:0] S_SHIFT_RD  = 4'd4;
  localparam logic [3:0] S_SHIFT_WR  = 4'd5;
  localparam logic [3:0] S_READ_RD   = 4'd6;
  localparam logic [3:0] S_READ_DATA = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0]                        state_r, state_nxt;
  logic [spta_pkg::CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [DEGREE_BITS-1:0]            deg_r, deg_nxt;
  spta_pkg::coeff_t                  coef_r, coef_nxt;
  logic [IDX_W-1:0]                  idx_r, idx_nxt;
  logic [CNT_W-1:0]                  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]                  sh_r, sh_nxt;
  logic [CNT_W-1:0]                  cnt_r, cnt_nxt;
  logic [spta_pkg::STATUS_W-1:0]     status_r, status_nxt;
  logic [DEGREE_BITS-1:0]            rdeg_r, rdeg_nxt;
  spta_pkg::coeff_t                  rcoef_r, rcoef_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]                  out_cnt_r, out_cnt_nxt;
  logic [DEGREE_BITS-1:0]            out_deg_r, out_deg_nxt;
  spta_pkg::coeff_t                  out_coef_r, out_coef_nxt;
  logic [spta_pkg::STATUS_W-1:0]     out_status_r, out_status_nxt;

  logic                              ram_we;
  logic [IDX_W-1:0]                  ram_waddr;
  logic [ENT_W-1:0]                  ram_wdata;
  logic [IDX_W-1:0]                  ram_raddr;
  logic [ENT_W-1:0]                  ram_rdata;
  logic [DEGREE_BITS-1:0]            ent_deg;
  spta_pkg::coeff_t                  ent_coef;

  spta_pkg::alu_ctrl_t               alu_ctrl;
  spta_pkg::alu_res_t                alu_res;

  logic                              accept_in;
  logic                              out_free;

  assign ent_deg  = ram_rdata[ENT_W-1:spta_pkg::COEFF_W];
  assign ent_coef = ram_rdata[spta_pkg::COEFF_W-1:0];

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  spta_term_ram #(
    .DEPTH (MAX_TERMS),
    .DW    (ENT_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared adder: accumulate on a match, zero-based for an insertion
  always_comb begin
    alu_ctrl.sub     = (cmd_r == spta_pkg::CMD_SUB);
    alu_ctrl.acc     = (state_r == S_SCAN_CHK) ? ent_coef : '0;
    alu_ctrl.operand = coef_r;
  end

  spta_sat_alu u_alu (
    .ctrl   (alu_ctrl),
    .result (alu_res)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    deg_nxt    = deg_r;
    coef_nxt   = coef_r;
    idx_nxt    = idx_r;
    ptr_nxt    = ptr_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    status_nxt = status_r;
    rdeg_nxt   = rdeg_r;
    rcoef_nxt  = rcoef_r;
    ram_we     = 1'b0;
    ram_waddr  = ptr_r[IDX_W-1:0];
    ram_wdata  = {deg_r, alu_res.res};
    ram_raddr  = ptr_r[IDX_W-1:0];

    out_valid_nxt  = out_valid_r && !out_ready;
    out_cnt_nxt    = out_cnt_r;
    out_deg_nxt    = out_deg_r;
    out_coef_nxt   = out_coef_r;
    out_status_nxt = out_status_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          cmd_nxt    = in_command;
          deg_nxt    = in_term_degree;
          coef_nxt   = in_term_coeff;
          idx_nxt    = in_read_index;
          ptr_nxt    = '0;
          status_nxt = spta_pkg::ST_OK;
          rdeg_nxt   = '0;
          rcoef_nxt  = '0;
          case (in_command)
            spta_pkg::CMD_ADD, spta_pkg::CMD_SUB: begin
              state_nxt = S_SCAN_RD;
            end
            spta_pkg::CMD_REPLACE: begin
              // Overwrite the top entry and shrink the table to one term
              ram_we    = 1'b1;
              ram_waddr = '0;
              ram_wdata = {in_term_degree, in_term_coeff};
              cnt_nxt   = CNT_W'(1);
              state_nxt = S_DONE;
            end
            default: begin
              if (CNT_W'(in_read_index) < cnt_r) begin
                state_nxt = S_READ_RD;
              end else begin
                status_nxt = spta_pkg::ST_BAD_IDX;
                state_nxt  = S_DONE;
              end
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        // Issue the read of the next entry, or stop at the end of the table
        if (ptr_r == cnt_r) begin
          state_nxt = S_INSERT;
        end else begin
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (ent_deg == deg_r) begin
          // Accumulate into the matching term
          ram_we     = 1'b1;
          status_nxt = alu_res.sat ? spta_pkg::ST_SAT : spta_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else if (ent_deg > deg_r) begin
          ptr_nxt   = ptr_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_INSERT;
        end
      end
      S_INSERT: begin
        // Drop the term when full, else open a gap at the pointer
        if (cnt_r == CNT_W'(MAX_TERMS)) begin
          status_nxt = spta_pkg::ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          sh_nxt    = cnt_r;
          state_nxt = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        ram_raddr = IDX_W'(sh_r - CNT_W'(1));
        if (sh_r == ptr_r) begin
          // Gap reached: place the new term
          ram_we     = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          status_nxt = alu_res.sat ? spta_pkg::ST_SAT : spta_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // Move the entry above down by one place
        ram_we    = 1'b1;
        ram_waddr = sh_r[IDX_W-1:0];
        ram_wdata = ram_rdata;
        sh_nxt    = sh_r - CNT_W'(1);
        state_nxt = S_SHIFT_RD;
      end
      S_READ_RD: begin
        ram_raddr = idx_r;
        state_nxt = S_READ_DATA;
      end
      S_READ_DATA: begin
        rdeg_nxt  = ent_deg;
        rcoef_nxt = ent_coef;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cnt_nxt    = cnt_r;
          out_deg_nxt    = rdeg_r;
          out_coef_nxt   = rcoef_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    deg_r        <= deg_nxt;
    coef_r       <= coef_nxt;
    idx_r        <= idx_nxt;
    ptr_r        <= ptr_nxt;
    sh_r         <= sh_nxt;
    status_r     <= status_nxt;
    rdeg_r       <= rdeg_nxt;
    rcoef_r      <= rcoef_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_deg_r    <= out_deg_nxt;
    out_coef_r   <= out_coef_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_term_count = out_cnt_r;
  assign out_degree     = out_deg_r;
  assign out_coeff      = out_coef_r;
  assign out_status     = out_status_r;

  // Table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_TERMS))
    else $error("term count above capacity");

  // A dropped term is only reported for a full table
  a_full_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == spta_pkg::ST_FULL |-> out_term_count == CNT_W'(MAX_TERMS))
    else $error("full status with free room");

  // A replace leaves exactly one term
  a_replace_one: assert property (@(posedge clk) disable iff (!rst_n)
    accept_in && in_command == spta_pkg::CMD_REPLACE |=> cnt_r == CNT_W'(1))
    else $error("replace did not leave one term");

  // Shifting never passes the insertion point
  a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT_WR |-> sh_r > ptr_r)
    else $error("shift below insertion point");

endmodule
